FILE: src/mgtl_pkg.sv
// Shared constants and the glyph descriptor type of the text layout block.
package mgtl_pkg;

    // Configuration port
    localparam int CFG_DATA_BITS  = 12;
    localparam int CFG_INDEX_BITS = 3;

    localparam logic [CFG_INDEX_BITS-1:0] REG_START_X      = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_START_Y      = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LEFT_MARGIN  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RIGHT_MARGIN = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_INK_COLOR    = 3'd4;

    localparam int RIGHT_MARGIN_RESET = 1024;
    localparam int INK_COLOR_RESET    = 15;

    // Field widths
    localparam int COORD_BITS_MAX = 16;
    localparam int ADDR_BITS      = 20;
    localparam int COLOR_BITS     = 8;
    localparam int BYTE_BITS      = 8;

    // Glyph geometry
    localparam int ROW_BITS = 4;
    localparam logic [ROW_BITS-1:0] ROW_LAST = 4'd15;
    localparam int LINE_PITCH     = 16;
    localparam int ASCII_ADVANCE  = 8;
    localparam int HANZI_ADVANCE  = 16;
    localparam int ASCII_Y_OFFSET = 3;

    // Byte classes
    localparam logic [BYTE_BITS-1:0] BYTE_END    = 8'h00;
    localparam logic [BYTE_BITS-1:0] ASCII_LIMIT = 8'd127;
    localparam logic [BYTE_BITS-1:0] GB_LOW      = 8'hA1;
    localparam logic [BYTE_BITS-1:0] GB_HIGH     = 8'hFE;
    localparam int GB_CELL_BITS = 7;
    localparam int GB_INDEX_BITS = 14;
    localparam logic [GB_INDEX_BITS-1:0] GB_ROW_CELLS = 14'd94;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_BITS = 1;
    localparam int QUEUE_COUNT_BITS = 2;

    // One glyph as handed from the front to the back
    typedef struct packed {
        logic                      font_select;
        logic                      glyph_valid;
        logic [ADDR_BITS-1:0]      base_address;
        logic [COORD_BITS_MAX-1:0] x;
        logic [COORD_BITS_MAX:0]   y_base;
        logic [COLOR_BITS-1:0]     color;
    } glyph_desc_t;

endpackage

FILE: src/mgtl_front.sv
// Front end: configuration registers, byte classification, cursor and wrap.
module mgtl_front
    import mgtl_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      push,
    output logic                      full,
    input  logic [BYTE_BITS-1:0]      text_byte,
    output logic                      q_push,
    output glyph_desc_t               q_data,
    input  logic                      q_full
);

    localparam logic [COORD_BITS:0] CMAX = {1'b0, {COORD_BITS{1'b1}}};
    localparam logic [COORD_BITS_MAX:0] CMAX_WIDE =
        (17'd1 << COORD_BITS) - 17'd1;
    localparam logic [COORD_BITS_MAX:0] RM_WIDE =
        (17'(RIGHT_MARGIN_RESET) > CMAX_WIDE) ? CMAX_WIDE : 17'(RIGHT_MARGIN_RESET);
    localparam logic [COORD_BITS:0] PITCH      = (COORD_BITS+1)'(LINE_PITCH);
    localparam logic [COORD_BITS:0] ADV_ASCII  = (COORD_BITS+1)'(ASCII_ADVANCE);
    localparam logic [COORD_BITS:0] ADV_HANZI  = (COORD_BITS+1)'(HANZI_ADVANCE);

    function automatic logic [COORD_BITS-1:0] sat(input logic [COORD_BITS:0] s);
        return (s > CMAX) ? CMAX[COORD_BITS-1:0] : s[COORD_BITS-1:0];
    endfunction

    logic [COORD_BITS-1:0] start_x_reg, start_y_reg, left_margin_reg, right_margin_reg;
    logic [COLOR_BITS-1:0] ink_color_reg;
    logic [COORD_BITS-1:0] cursor_x_reg, cursor_x_next;
    logic [COORD_BITS-1:0] cursor_y_reg, cursor_y_next;
    logic [BYTE_BITS-1:0]  lead_byte_reg, lead_byte_next;
    logic                  lead_pending_reg, lead_pending_next;
    logic                  string_active_reg, string_active_next;

    logic [COORD_BITS_MAX:0]  cfg_wide;
    logic [COORD_BITS-1:0]    cfg_coord;
    logic                     accept, is_end, is_ascii, is_glyph, wrap, gb_ok;
    logic [COORD_BITS-1:0]    x_cur, y_cur, x_glyph, y_glyph, x_after;
    logic [GB_CELL_BITS-1:0]  zone, pos;
    logic [GB_INDEX_BITS-1:0] gb_index;
    logic [BYTE_BITS-1:0]     zone_full, pos_full;

    // Clamp written coordinates into the coordinate range
    assign cfg_wide  = {{(COORD_BITS_MAX+1-CFG_DATA_BITS){1'b0}}, cfg_data};
    assign cfg_coord = (cfg_wide > CMAX_WIDE) ? CMAX_WIDE[COORD_BITS-1:0]
                                              : cfg_wide[COORD_BITS-1:0];

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg      <= '0;
            start_y_reg      <= '0;
            left_margin_reg  <= '0;
            right_margin_reg <= RM_WIDE[COORD_BITS-1:0];
            ink_color_reg    <= COLOR_BITS'(INK_COLOR_RESET);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_START_X:      start_x_reg      <= cfg_coord;
                REG_START_Y:      start_y_reg      <= cfg_coord;
                REG_LEFT_MARGIN:  left_margin_reg  <= cfg_coord;
                REG_RIGHT_MARGIN: right_margin_reg <= cfg_coord;
                REG_INK_COLOR:    ink_color_reg    <= cfg_data[COLOR_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // Classify the byte and place the glyph
    assign full     = q_full;
    assign accept   = push && !q_full;
    assign is_end   = (text_byte == BYTE_END);
    assign is_ascii = !lead_pending_reg && (text_byte < ASCII_LIMIT);
    assign is_glyph = !is_end && (lead_pending_reg || is_ascii);

    assign x_cur   = string_active_reg ? cursor_x_reg : start_x_reg;
    assign y_cur   = string_active_reg ? cursor_y_reg : start_y_reg;
    assign wrap    = (x_cur >= right_margin_reg);
    assign x_glyph = wrap ? left_margin_reg : x_cur;
    assign y_glyph = wrap ? sat({1'b0, y_cur} + PITCH) : y_cur;
    assign x_after = sat({1'b0, x_glyph} + (lead_pending_reg ? ADV_HANZI : ADV_ASCII));

    // Hanzi font index from zone and position
    assign gb_ok = (lead_byte_reg >= GB_LOW) && (lead_byte_reg <= GB_HIGH)
                && (text_byte >= GB_LOW) && (text_byte <= GB_HIGH);
    assign zone_full = lead_byte_reg - GB_LOW;
    assign pos_full  = text_byte - GB_LOW;
    assign zone      = zone_full[GB_CELL_BITS-1:0];
    assign pos       = pos_full[GB_CELL_BITS-1:0];
    assign gb_index  = GB_INDEX_BITS'(zone) * GB_ROW_CELLS + GB_INDEX_BITS'(pos);

    // Build the descriptor for the queue
    always_comb
    begin
        q_data.font_select = lead_pending_reg;
        q_data.glyph_valid = lead_pending_reg ? gb_ok : 1'b1;
        if (lead_pending_reg)
            q_data.base_address = gb_ok ? {1'b0, gb_index, 5'b0} : '0;
        else
            q_data.base_address = {8'b0, text_byte, 4'b0};
        q_data.x      = COORD_BITS_MAX'(x_glyph);
        q_data.y_base = (COORD_BITS_MAX+1)'(y_glyph)
                      + (lead_pending_reg ? '0 : (COORD_BITS_MAX+1)'(ASCII_Y_OFFSET));
        q_data.color  = ink_color_reg;
    end

    assign q_push = accept && is_glyph;

    // Advance the cursor and the lead byte state
    always_comb
    begin
        cursor_x_next      = cursor_x_reg;
        cursor_y_next      = cursor_y_reg;
        lead_byte_next     = lead_byte_reg;
        lead_pending_next  = lead_pending_reg;
        string_active_next = string_active_reg;
        if (accept)
        begin
            if (is_end)
            begin
                string_active_next = 1'b0;
                lead_pending_next  = 1'b0;
                lead_byte_next     = '0;
            end
            else
            begin
                string_active_next = 1'b1;
                if (is_glyph)
                begin
                    cursor_x_next     = x_after;
                    cursor_y_next     = y_glyph;
                    lead_pending_next = 1'b0;
                    lead_byte_next    = '0;
                end
                else
                begin
                    cursor_x_next     = x_cur;
                    cursor_y_next     = y_cur;
                    lead_pending_next = 1'b1;
                    lead_byte_next    = text_byte;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg      <= '0;
            cursor_y_reg      <= '0;
            lead_byte_reg     <= '0;
            lead_pending_reg  <= 1'b0;
            string_active_reg <= 1'b0;
        end
        else
        begin
            cursor_x_reg      <= cursor_x_next;
            cursor_y_reg      <= cursor_y_next;
            lead_byte_reg     <= lead_byte_next;
            lead_pending_reg  <= lead_pending_next;
            string_active_reg <= string_active_next;
        end
    end

endmodule

FILE: src/mgtl_queue.sv
// Two-entry queue of glyph descriptors between front and back.
module mgtl_queue
    import mgtl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_push,
    input  glyph_desc_t q_wdata,
    output logic        q_full,
    input  logic        q_pop,
    output glyph_desc_t q_rdata,
    output logic        q_empty
);

    glyph_desc_t                 entries [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_COUNT_BITS-1:0] count_reg, count_next;
    logic                        do_push, do_pop;

    assign q_full  = (count_reg == QUEUE_COUNT_BITS'(QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_push = q_push && !q_full;
    assign do_pop  = q_pop && !q_empty;
    assign q_rdata = entries[rd_ptr_reg];

    // Track the fill level
    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    // Store an item
    always_ff @(posedge clk)
    begin
        if (do_push)
            entries[wr_ptr_reg] <= q_wdata;
    end

    // Advance the pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

FILE: src/mgtl_back.sv
// Back end: expands each glyph into sixteen row commands behind an output register.
module mgtl_back
    import mgtl_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_empty,
    input  glyph_desc_t           q_data,
    output logic                  q_pop,
    input  logic                  pop,
    output logic                  empty,
    output logic                  font_select,
    output logic [ADDR_BITS-1:0]  font_address,
    output logic [COORD_BITS-1:0] screen_x,
    output logic [COORD_BITS-1:0] screen_y,
    output logic [COLOR_BITS-1:0] row_color,
    output logic                  glyph_valid,
    output logic                  last_row
);

    localparam logic [COORD_BITS_MAX:0] CMAX_WIDE =
        (17'd1 << COORD_BITS) - 17'd1;

    logic [ROW_BITS-1:0]     row_reg, row_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    font_select_reg, glyph_valid_reg, last_row_reg;
    logic [ADDR_BITS-1:0]    font_address_reg, addr_row;
    logic [COORD_BITS-1:0]   screen_x_reg, screen_y_reg, y_row;
    logic [COLOR_BITS-1:0]   row_color_reg;
    logic [COORD_BITS_MAX:0] y_sum;
    logic [ADDR_BITS-1:0]    row_step;
    logic                    load, take;

    // Advance when the output register is free or being drained
    assign load  = !out_valid_reg || pop;
    assign take  = load && !q_empty;
    assign q_pop = take && (row_reg == ROW_LAST);

    // Form the current row
    assign row_step = q_data.font_select ? ADDR_BITS'({row_reg, 1'b0})
                                         : ADDR_BITS'(row_reg);
    assign addr_row = q_data.glyph_valid ? (q_data.base_address + row_step) : '0;
    assign y_sum    = q_data.y_base + (COORD_BITS_MAX+1)'(row_reg);
    assign y_row    = (y_sum > CMAX_WIDE) ? CMAX_WIDE[COORD_BITS-1:0]
                                          : y_sum[COORD_BITS-1:0];

    always_comb
    begin
        row_next       = row_reg;
        out_valid_next = out_valid_reg;
        if (take)
        begin
            row_next       = row_reg + 1'b1;
            out_valid_next = 1'b1;
        end
        else if (load)
            out_valid_next = 1'b0;
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the row command
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            font_select_reg  <= q_data.font_select;
            font_address_reg <= addr_row;
            screen_x_reg     <= q_data.x[COORD_BITS-1:0];
            screen_y_reg     <= y_row;
            row_color_reg    <= q_data.color;
            glyph_valid_reg  <= q_data.glyph_valid;
            last_row_reg     <= (row_reg == ROW_LAST);
        end
    end

    assign empty        = !out_valid_reg;
    assign font_select  = font_select_reg;
    assign font_address = font_address_reg;
    assign screen_x     = screen_x_reg;
    assign screen_y     = screen_y_reg;
    assign row_color    = row_color_reg;
    assign glyph_valid  = glyph_valid_reg;
    assign last_row     = last_row_reg;

    // Row counter is back at zero once the last row is shown
    a_last_row_counter: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && last_row_reg) |-> (row_reg == '0))
        else $error("row counter not rewound after last row");

    // A shown middle row keeps its glyph at the head of the queue
    a_glyph_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !last_row_reg) |-> (!q_empty && row_reg != '0))
        else $error("glyph left the queue before its last row");

    a_font_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !last_row_reg) |-> (font_select_reg == q_data.font_select))
        else $error("row command font differs from glyph in progress");

endmodule

FILE: src/mixed_gb2312_ascii_text_layout_top.sv
// A glyph byte accepted by the front end is written into the descriptor queue, and its
// first row command is then loaded into the back end's output register. Each glyph gives
// 16 row commands from the back end's row counter, one per cycle while the output register
// is free or popped; lead and zero bytes add no descriptor. The two-entry queue lets input
// run ahead of output. Reset: cursor and string state clear, configuration registers take
// their reset values, and the block accepts items right away with no clearing pass.
module mixed_gb2312_ascii_text_layout_top
    import mgtl_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      push,
    output logic                      full,
    input  logic [BYTE_BITS-1:0]      text_byte,
    input  logic                      pop,
    output logic                      empty,
    output logic                      font_select,
    output logic [ADDR_BITS-1:0]      font_address,
    output logic [COORD_BITS-1:0]     screen_x,
    output logic [COORD_BITS-1:0]     screen_y,
    output logic [COLOR_BITS-1:0]     row_color,
    output logic                      glyph_valid,
    output logic                      last_row
);

    logic        q_push, q_full, q_pop, q_empty;
    glyph_desc_t q_wdata, q_rdata;

    mgtl_front #(.COORD_BITS(COORD_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .text_byte (text_byte),
        .q_push    (q_push),
        .q_data    (q_wdata),
        .q_full    (q_full)
    );

    mgtl_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_push  (q_push),
        .q_wdata (q_wdata),
        .q_full  (q_full),
        .q_pop   (q_pop),
        .q_rdata (q_rdata),
        .q_empty (q_empty)
    );

    mgtl_back #(.COORD_BITS(COORD_BITS)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_data       (q_rdata),
        .q_pop        (q_pop),
        .pop          (pop),
        .empty        (empty),
        .font_select  (font_select),
        .font_address (font_address),
        .screen_x     (screen_x),
        .screen_y     (screen_y),
        .row_color    (row_color),
        .glyph_valid  (glyph_valid),
        .last_row     (last_row)
    );

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the mixed GB2312/ASCII text layout block.
module tb_top
    import mgtl_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD      = 12;
    localparam int COORD_MAX  = (1 << COORD) - 1;
    localparam int GLYPH_ROWS = 16;
    localparam int HANZI_GLYPH_BYTES = 32;
    localparam int ASCII_GLYPH_BYTES = 16;
    localparam int NPROBE     = 24;
    localparam int NPHASE     = 8;
    localparam int PHASE_BYTES = 48;
    localparam int IDLE_GAP   = 4;
    localparam int DRAIN_CYCLES = 32;
    localparam int REPORT_LIMIT = 10;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_HI = 3'd7;
    localparam logic [7:0] STALL_SEED = 8'b1011_0110;

    typedef enum int {RX_STEADY, RX_COIN, RX_PATTERN, RX_SPARSE} rx_mode_t;

    // One row command as the block should present it
    typedef struct {
        logic                  sel;
        logic [ADDR_BITS-1:0]  addr;
        logic [COORD-1:0]      x;
        logic [COORD-1:0]      y;
        logic [COLOR_BITS-1:0] color;
        logic                  valid;
        logic                  last;
    } row_cmd_t;

    // Directed byte; rows that complete a glyph may carry a hand-typed first row
    typedef struct packed {
        logic [BYTE_BITS-1:0] code;
        logic                 typed;
        logic                 sel;
        logic [ADDR_BITS-1:0] addr;
        logic [COORD-1:0]     x;
        logic [COORD-1:0]     y;
        logic                 valid;
    } probe_t;

    localparam probe_t PROBES [NPROBE] = '{
        '{8'h41, 1'b1, 1'b0, 20'd1040,   12'd0,   12'd3, 1'b1},
        '{8'h01, 1'b1, 1'b0, 20'd16,     12'd8,   12'd3, 1'b1},
        '{8'h7E, 1'b1, 1'b0, 20'd2016,   12'd16,  12'd3, 1'b1},
        '{8'hA1, 1'b0, 1'b0, 20'd0,      12'd0,   12'd0, 1'b0},
        '{8'hA1, 1'b1, 1'b1, 20'd0,      12'd24,  12'd0, 1'b1},
        '{8'hF7, 1'b0, 1'b0, 20'd0,      12'd0,   12'd0, 1'b0},
        '{8'hFE, 1'b1, 1'b1, 20'd261664, 12'd40,  12'd0, 1'b1},
        '{8'h7F, 1'b0, 1'b0, 20'd0,      12'd0,   12'd0, 1'b0},
        '{8'h41, 1'b1, 1'b1, 20'd0,      12'd56,  12'd0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 20'd0,      12'd0,   12'd0, 1'b0},
        '{8'hA1, 1'b1, 1'b1, 20'd0,      12'd72,  12'd0, 1'b0},
        '{8'hA1, 1'b0, 1'b0, 20'd0,      12'd0,   12'd0, 1'b0},
        '{8'hA0, 1'b1, 1'b1, 20'd0,      12'd88,  12'd0, 1'b0},
        '{8'h80, 1'b0, 1'b0, 20'd0,      12'd0,   12'd0, 1'b0},
        '{8'h80, 1'b1, 1'b1, 20'd0,      12'd104, 12'd0, 1'b0},
        '{8'hB0, 1'b0, 1'b0, 20'd0,      12'd0,   12'd0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 20'd0,      12'd0,   12'd0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 20'd0,      12'd0,   12'd0, 1'b0},
        '{8'hFE, 1'b0, 1'b0, 20'd0,      12'd0,   12'd0, 1'b0},
        '{8'hA1, 1'b1, 1'b1, 20'd279744, 12'd0,   12'd0, 1'b1},
        '{8'hFF, 1'b0, 1'b0, 20'd0,      12'd0,   12'd0, 1'b0},
        '{8'hFF, 1'b1, 1'b1, 20'd0,      12'd16,  12'd0, 1'b0},
        '{8'h2A, 1'b0, 1'b0, 20'd0,      12'd0,   12'd0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 20'd0,      12'd0,   12'd0, 1'b0}
    };

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_write = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
    logic                      push = 1'b0;
    logic                      full;
    logic [BYTE_BITS-1:0]      text_byte = '0;
    logic                      pop;
    logic                      empty;
    logic                      font_select;
    logic [ADDR_BITS-1:0]      font_address;
    logic [COORD-1:0]          screen_x;
    logic [COORD-1:0]          screen_y;
    logic [COLOR_BITS-1:0]     row_color;
    logic                      glyph_valid;
    logic                      last_row;

    // Layout state and register copies kept by the testbench
    int                   set_start_x, set_start_y, set_left, set_right;
    logic [COLOR_BITS-1:0] set_ink;
    int                   pen_x, pen_y;
    logic [BYTE_BITS-1:0] held_lead;
    bit                   lead_held, in_string;

    row_cmd_t             pending_rows[$];
    logic [BYTE_BITS-1:0] text_plan[$];

    rx_mode_t  stall_mode = RX_STEADY;
    logic [7:0] stall_bits;
    int errors, bytes_sent, rows_checked, hanzi_rows, bad_rows, wraps, settings;

    mixed_gb2312_ascii_text_layout_top #(.COORD_BITS(COORD)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .push         (push),
        .full         (full),
        .text_byte    (text_byte),
        .pop          (pop),
        .empty        (empty),
        .font_select  (font_select),
        .font_address (font_address),
        .screen_x     (screen_x),
        .screen_y     (screen_y),
        .row_color    (row_color),
        .glyph_valid  (glyph_valid),
        .last_row     (last_row)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Cap the run in case the block hangs
    initial
    begin
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int clamp_coord(input int v);
        return (v > COORD_MAX) ? COORD_MAX : v;
    endfunction

    function automatic bit gb_byte_ok(input logic [BYTE_BITS-1:0] b);
        return (b >= GB_LOW) && (b <= GB_HIGH);
    endfunction

    // Wrap if needed, then queue the sixteen rows of one glyph
    task automatic queue_glyph_rows(input logic sel, input int base, input int stride,
                                    input int yoff, input logic ok);
        row_cmd_t rc;
        if (pen_x >= set_right)
        begin
            pen_x = set_left;
            pen_y = clamp_coord(pen_y + LINE_PITCH);
            wraps++;
        end
        for (int r = 0; r < GLYPH_ROWS; r++)
        begin
            rc.sel   = sel;
            rc.addr  = ok ? ADDR_BITS'(base + stride * r) : '0;
            rc.x     = COORD'(pen_x);
            rc.y     = COORD'(clamp_coord(pen_y + yoff + r));
            rc.color = set_ink;
            rc.valid = ok;
            rc.last  = (r == int'(ROW_LAST));
            pending_rows.push_back(rc);
        end
    endtask

    // Advance the layout state by one accepted byte
    task automatic lay_out_byte(input logic [BYTE_BITS-1:0] b);
        bit ok;
        int base;
        if (b == BYTE_END)
        begin
            in_string = 1'b0;
            lead_held = 1'b0;
            held_lead = '0;
        end
        else
        begin
            if (!in_string)
            begin
                pen_x = set_start_x;
                pen_y = set_start_y;
                in_string = 1'b1;
            end
            if (lead_held)
            begin
                ok = gb_byte_ok(held_lead) && gb_byte_ok(b);
                base = ok ? (int'(GB_ROW_CELLS) * (int'(held_lead) - int'(GB_LOW))
                             + (int'(b) - int'(GB_LOW))) * HANZI_GLYPH_BYTES : 0;
                lead_held = 1'b0;
                held_lead = '0;
                queue_glyph_rows(1'b1, base, 2, 0, ok);
                pen_x = clamp_coord(pen_x + HANZI_ADVANCE);
            end
            else if (b < ASCII_LIMIT)
            begin
                queue_glyph_rows(1'b0, int'(b) * ASCII_GLYPH_BYTES, 1, ASCII_Y_OFFSET, 1'b1);
                pen_x = clamp_coord(pen_x + ASCII_ADVANCE);
            end
            else
            begin
                held_lead = b;
                lead_held = 1'b1;
            end
        end
    endtask

    // Offer one byte and hold it until the block takes it
    task automatic send_byte(input logic [BYTE_BITS-1:0] b);
        text_byte <= b;
        push <= 1'b1;
        @(posedge clk);
        while (full) @(posedge clk);
        bytes_sent++;
        lay_out_byte(b);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_START_X:      set_start_x = clamp_coord(int'(data));
            REG_START_Y:      set_start_y = clamp_coord(int'(data));
            REG_LEFT_MARGIN:  set_left    = clamp_coord(int'(data));
            REG_RIGHT_MARGIN: set_right   = clamp_coord(int'(data));
            REG_INK_COLOR:    set_ink     = data[COLOR_BITS-1:0];
            default:          ;
        endcase
    endtask

    task automatic set_config(input int sx, input int sy, input int lm, input int rm,
                              input logic [CFG_DATA_BITS-1:0] ink);
        write_reg(REG_START_X, CFG_DATA_BITS'(sx));
        write_reg(REG_START_Y, CFG_DATA_BITS'(sy));
        write_reg(REG_LEFT_MARGIN, CFG_DATA_BITS'(lm));
        write_reg(REG_RIGHT_MARGIN, CFG_DATA_BITS'(rm));
        write_reg(REG_INK_COLOR, ink);
        // Unmapped index: must leave every register alone
        write_reg(CFG_INDEX_BITS'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                  CFG_DATA_BITS'($urandom));
        cfg_write <= 1'b0;
        settings++;
    endtask

    // Let the last rows drain, then allow a lead or end byte to settle
    task automatic wait_idle();
        while (pending_rows.size() != 0) @(posedge clk);
        repeat (IDLE_GAP) @(posedge clk);
    endtask

    // Fill the plan with mostly well-formed glyphs and some broken pairs
    task automatic build_plan();
        int pick;
        text_plan.delete();
        while (text_plan.size() < PHASE_BYTES)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                text_plan.push_back(BYTE_BITS'($urandom_range(1, 126)));
            else if (pick < 75)
            begin
                text_plan.push_back(BYTE_BITS'($urandom_range(GB_LOW, GB_HIGH)));
                text_plan.push_back(BYTE_BITS'($urandom_range(GB_LOW, GB_HIGH)));
            end
            else if (pick < 85)
            begin
                text_plan.push_back(BYTE_BITS'($urandom_range(127, 255)));
                text_plan.push_back(BYTE_BITS'($urandom_range(1, 255)));
            end
            else if (pick < 92)
            begin
                text_plan.push_back(BYTE_BITS'($urandom_range(127, 255)));
                text_plan.push_back(BYTE_END);
            end
            else
                text_plan.push_back(BYTE_END);
        end
        text_plan.push_back(BYTE_END);
    endtask

    // Send the plan in bursts with optional gaps between them
    task automatic send_plan(input bit with_gaps);
        int burst;
        int gap;
        while (text_plan.size() != 0)
        begin
            burst = $urandom_range(1, 16);
            while (burst > 0 && text_plan.size() != 0)
            begin
                send_byte(text_plan.pop_front());
                burst--;
            end
            gap = with_gaps ? $urandom_range(0, 5) : 0;
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        push <= 1'b0;
    endtask

    // Receiver stalls on a mode picked per phase
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
            stall_bits <= STALL_SEED;
        end
        else
        begin
            stall_bits <= {stall_bits[0], stall_bits[7:1]};
            case (stall_mode)
                RX_STEADY:  pop <= 1'b1;
                RX_COIN:    pop <= ($urandom_range(0, 3) != 0);
                RX_PATTERN: pop <= stall_bits[0];
                default:    pop <= ($urandom_range(0, 11) == 0);
            endcase
        end
    end

    // Compare each accepted row with the oldest expectation
    always @(posedge clk)
    begin
        row_cmd_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_rows.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("unexpected row: sel=%0d addr=%h x=%0d y=%0d", font_select,
                             font_address, screen_x, screen_y);
            end
            else
            begin
                want = pending_rows.pop_front();
                rows_checked++;
                if (want.sel) hanzi_rows++;
                if (!want.valid) bad_rows++;
                if (font_select !== want.sel || font_address !== want.addr ||
                    screen_x !== want.x || screen_y !== want.y ||
                    row_color !== want.color || glyph_valid !== want.valid ||
                    last_row !== want.last)
                begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display({"row %0d mismatch: want sel=%0d addr=%h x=%0d y=%0d c=%0d ",
                                  "v=%0d l=%0d, got sel=%0d addr=%h x=%0d y=%0d c=%0d ",
                                  "v=%0d l=%0d"}, rows_checked, want.sel, want.addr,
                                 want.x, want.y, want.color, want.valid, want.last,
                                 font_select, font_address, screen_x, screen_y, row_color,
                                 glyph_valid, last_row);
                end
            end
        end
    end

    // Main sequence: reset, directed table, then register phases with random text, the later ones on random settings
    initial
    begin
        row_cmd_t head;
        int first;
        set_start_x = 0;
        set_start_y = 0;
        set_left    = 0;
        set_right   = RIGHT_MARGIN_RESET;
        set_ink     = COLOR_BITS'(INK_COLOR_RESET);
        pen_x = 0;
        pen_y = 0;
        held_lead = '0;
        lead_held = 1'b0;
        in_string = 1'b0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table; override the first row where it is typed in
        for (int i = 0; i < NPROBE; i++)
        begin
            send_byte(PROBES[i].code);
            if (PROBES[i].typed)
            begin
                first = pending_rows.size() - GLYPH_ROWS;
                head = pending_rows[first];
                head.sel   = PROBES[i].sel;
                head.addr  = PROBES[i].addr;
                head.x     = PROBES[i].x;
                head.y     = PROBES[i].y;
                head.valid = PROBES[i].valid;
                pending_rows[first] = head;
            end
            if ($urandom_range(0, 2) == 0)
            begin
                push <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
        end
        push <= 1'b0;
        wait_idle();

        for (int ph = 1; ph <= NPHASE; ph++)
        begin
            case (ph)
                1: set_config(0, 0, 0, 64, 12'hFAA);
                2: set_config(COORD_MAX, COORD_MAX, COORD_MAX, 0, 12'h0FF);
                3: set_config(4000, 4000, 8, COORD_MAX, 12'hF00);
                4: set_config(0, 4064, 0, 200, CFG_DATA_BITS'($urandom));
                default: set_config($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                                    $urandom_range(0, 255), $urandom_range(0, COORD_MAX),
                                    CFG_DATA_BITS'($urandom));
            endcase
            stall_mode = rx_mode_t'(ph % 4);
            build_plan();
            send_plan(ph % 3 != 0);
            wait_idle();
        end

        // Catch any stray rows after the last expectation
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Covered %0d text bytes over %0d register settings, %0d line wraps.",
                 bytes_sent, settings + 1, wraps);
        $display("Checked %0d row commands: %0d hanzi, %0d invalid; %0d errors.",
                 rows_checked, hanzi_rows, bad_rows, errors);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: sim.f
src/mgtl_pkg.sv
src/mgtl_front.sv
src/mgtl_queue.sv
src/mgtl_back.sv
src/mixed_gb2312_ascii_text_layout_top.sv
tb/tb_top.sv
